### design/smoothing_3x3_stencil_core_defines.svh
// assertion macros used by the smoothing stencil checker
`ifndef SMOOTHING_3X3_STENCIL_CORE_DEFINES_SVH
`define SMOOTHING_3X3_STENCIL_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define SST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smoothing stencil check failed");

// condition must hold in the cycle after the trigger
`define SST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smoothing stencil check failed");

`endif

### design/sst_pkg.sv
// shared constants, config codes and stage types of the smoothing stencil
package sst_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned WEIGHT_FRAC = 14;
  localparam int unsigned MAX_SIZE    = 4096;
  localparam int unsigned MIN_SIZE    = 3;
  localparam int unsigned SIZE_W      = 13;
  localparam int unsigned IDX_W       = $clog2(MAX_SIZE);
  localparam int unsigned LINE_W      = 2 * SAMPLE_W;
  localparam int unsigned SUM_W       = SAMPLE_W + 2;
  localparam int unsigned PROD_W      = SUM_W + WEIGHT_W;
  localparam int unsigned CPROD_W     = SAMPLE_W + WEIGHT_W;
  localparam int unsigned ACC_W       = PROD_W + 2;
  localparam int unsigned SHR_W       = ACC_W - WEIGHT_FRAC;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int SAT_HI = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAT_LO = -(1 << (SAMPLE_W - 1));

  localparam logic signed [WEIGHT_W-1:0] CORNER_RST = WEIGHT_W'(819);
  localparam logic signed [WEIGHT_W-1:0] EDGE_RST   = WEIGHT_W'(1638);
  localparam logic signed [WEIGHT_W-1:0] CENTER_RST = WEIGHT_W'(6554);
  localparam logic [SIZE_W-1:0]          SIZE_RST   = SIZE_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORNER = 2'd0,
    CFG_EDGE   = 2'd1,
    CFG_CENTER = 2'd2,
    CFG_SIZE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] corner_wt;
    logic signed [WEIGHT_W-1:0] edge_wt;
    logic signed [WEIGHT_W-1:0] center_wt;
  } sst_weights_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } sst_pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    corner_sum;
    logic signed [SUM_W-1:0]    side_sum;
    logic signed [SAMPLE_W-1:0] center;
    sst_pos_t                   pos;
  } sst_sums_t;

endpackage

### design/sst_line_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module sst_line_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sst_window.sv
// raster counters, line buffer read-modify-write and the 3x3 window with its sums
module sst_window import sst_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SIZE_W-1:0]          image_size_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       sums_valid_o,
  input  logic                       sums_ready_i,
  output sst_sums_t                  sums_o
);

  logic [SIZE_W-1:0] size_n;
  logic [IDX_W-1:0]  col_q, col_d, row_q, row_d;
  logic              col_wrap;
  logic [SIZE_W-1:0] row_adv, col_inc, row_inc;
  logic [IDX_W-1:0]  cur_col, cur_row;
  logic              cur_inner, cur_last;
  logic              accept, s1_fire;

  logic                       s1_valid_q;
  logic                       s1_inner_q;
  logic                       s1_last_q;
  logic [IDX_W-1:0]           s1_col_q, s1_row_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;

  logic [LINE_W-1:0]          line_rdata;
  logic signed [SAMPLE_W-1:0] line_top, line_mid;
  logic signed [SAMPLE_W-1:0] win_q [6];

  // clamp the size register into the supported range
  always_comb begin
    if (image_size_i < SIZE_W'(MIN_SIZE)) begin
      size_n = SIZE_W'(MIN_SIZE);
    end else if (image_size_i > SIZE_W'(MAX_SIZE)) begin
      size_n = SIZE_W'(MAX_SIZE);
    end else begin
      size_n = image_size_i;
    end
  end

  // position of the arriving sample, wrapping if the size shrank
  always_comb begin
    col_wrap  = SIZE_W'(col_q) >= size_n;
    row_adv   = col_wrap ? SIZE_W'(row_q) + SIZE_W'(1) : SIZE_W'(row_q);
    cur_col   = col_wrap ? '0 : col_q;
    cur_row   = (row_adv >= size_n) ? '0 : row_adv[IDX_W-1:0];
    cur_inner = (cur_row >= IDX_W'(2)) && (cur_col >= IDX_W'(2));
    cur_last  = (SIZE_W'(cur_row) == size_n - SIZE_W'(1)) &&
                (SIZE_W'(cur_col) == size_n - SIZE_W'(1));
    col_inc   = SIZE_W'(cur_col) + SIZE_W'(1);
    row_inc   = SIZE_W'(cur_row) + SIZE_W'(1);
    if (col_inc >= size_n) begin
      col_d = '0;
      row_d = (row_inc >= size_n) ? '0 : row_inc[IDX_W-1:0];
    end else begin
      col_d = col_inc[IDX_W-1:0];
      row_d = cur_row;
    end
  end

  // border items leave without waiting on the multiply stages
  assign s1_fire    = s1_valid_q && (!s1_inner_q || sums_ready_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_inner_q  <= cur_inner;
      s1_last_q   <= cur_last;
      s1_col_q    <= cur_col;
      s1_row_q    <= cur_row;
      s1_sample_q <= sample_i;
    end
  end

  // entry holds {two rows above, one row above}; the column in flight is written
  // back before any later request can read it again, since a row has at least three columns
  sst_line_ram #(
    .DEPTH (MAX_SIZE),
    .WIDTH (LINE_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({line_mid, s1_sample_q}),
    .re_i    (accept),
    .raddr_i (cur_col),
    .rdata_o (line_rdata)
  );

  assign line_top = line_rdata[LINE_W-1:SAMPLE_W];
  assign line_mid = line_rdata[SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= line_top;
      win_q[4] <= line_mid;
      win_q[5] <= s1_sample_q;
    end
  end

  assign sums_valid_o = s1_valid_q && s1_inner_q;

  always_comb begin
    sums_o.corner_sum = SUM_W'(win_q[0]) + SUM_W'(win_q[2]) +
                        SUM_W'(line_top) + SUM_W'(s1_sample_q);
    sums_o.side_sum   = SUM_W'(win_q[3]) + SUM_W'(win_q[5]) +
                        SUM_W'(win_q[1]) + SUM_W'(line_mid);
    sums_o.center     = win_q[4];
    sums_o.pos.row    = s1_row_q - IDX_W'(1);
    sums_o.pos.col    = s1_col_q - IDX_W'(1);
    sums_o.pos.last   = s1_last_q;
  end

endmodule

### design/sst_mac.sv
// weighted sum, rounding, saturation and the output register
module sst_mac import sst_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sst_weights_t               weights_i,
  input  logic                       sums_valid_i,
  output logic                       sums_ready_o,
  input  sst_sums_t                  sums_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_value_o,
  output logic [IDX_W-1:0]           out_row_o,
  output logic [IDX_W-1:0]           out_col_o,
  output logic                       out_last_o
);

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (WEIGHT_FRAC - 1);
  localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(SAT_HI);
  localparam logic signed [SHR_W-1:0] SAT_MIN = SHR_W'(SAT_LO);

  logic      a_valid_q, b_valid_q, o_valid_q;
  logic      a_free, b_free, o_free;
  sst_sums_t a_q;

  logic signed [PROD_W-1:0]  b_corner_q, b_side_q, b_corner_d, b_side_d;
  logic signed [CPROD_W-1:0] b_center_q, b_center_d;
  sst_pos_t                  b_pos_q;

  logic signed [ACC_W-1:0]    acc;
  logic signed [SHR_W-1:0]    shr;
  logic signed [SAMPLE_W-1:0] value_d, o_value_q;
  sst_pos_t                   o_pos_q;

  assign o_free       = !o_valid_q || !out_stall_i;
  assign b_free       = !b_valid_q || o_free;
  assign a_free       = !a_valid_q || b_free;
  assign sums_ready_o = a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= sums_valid_i;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
      if (o_free) begin
        o_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && sums_valid_i) begin
      a_q <= sums_i;
    end
  end

  always_comb begin
    b_corner_d = $signed(a_q.corner_sum) * $signed(weights_i.corner_wt);
    b_side_d   = $signed(a_q.side_sum) * $signed(weights_i.edge_wt);
    b_center_d = $signed(a_q.center) * $signed(weights_i.center_wt);
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_valid_q) begin
      b_corner_q <= b_corner_d;
      b_side_q   <= b_side_d;
      b_center_q <= b_center_d;
      b_pos_q    <= a_q.pos;
    end
  end

  // floor shift after adding half an lsb gives round half up
  always_comb begin
    acc = ACC_W'(b_corner_q) + ACC_W'(b_side_q) + ACC_W'(b_center_q) + RND;
    shr = acc[ACC_W-1:WEIGHT_FRAC];
    if (shr > SAT_MAX) begin
      value_d = SAMPLE_W'(SAT_HI);
    end else if (shr < SAT_MIN) begin
      value_d = SAMPLE_W'(SAT_LO);
    end else begin
      value_d = shr[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free && b_valid_q) begin
      o_value_q <= value_d;
      o_pos_q   <= b_pos_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_value_o = o_value_q;
  assign out_row_o   = o_pos_q.row;
  assign out_col_o   = o_pos_q.col;
  assign out_last_o  = o_pos_q.last;

endmodule

### design/smoothing_3x3_stencil_core.sv
// 3x3 smoothing stencil over a raster pixel stream
// usage:
//   samples of a square image enter in raster order on in_valid_i / sample_i;
//   a request is taken at a clock edge with in_valid_i high and in_stall_o low
//   each sample that completes an interior 3x3 neighborhood yields one result
//   on out_valid_o with out_value_o, out_row_o, out_col_o of the center pixel;
//   out_last_o marks the last interior result of the frame; border samples
//   yield nothing
//   throughput is one sample per cycle while in_stall_o is low; a result
//   reaches out_valid_o through the window stage, sum stage, product stage
//   and output register
//   the line buffers are one ram with one read and one write port per cycle,
//   read at the incoming column and written back when the sample leaves the
//   window stage
//   when out_stall_i is held the output register keeps its result, the stages
//   behind it fill up, and in_stall_o rises once none is free; reset clears the
//   weights and size to defaults, the raster position and window; line buffer
//   contents come only from written rows; the user must write weights and size
//   (cfg_we_i/cfg_idx_i/cfg_data_i) only while idle, unenforced by the block
module smoothing_3x3_stencil_core import sst_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_value_o,
  output logic [IDX_W-1:0]           out_row_o,
  output logic [IDX_W-1:0]           out_col_o,
  output logic                       out_last_o
);

  sst_weights_t      weights_q;
  logic [SIZE_W-1:0] size_q;
  logic              sums_valid, sums_ready;
  sst_sums_t         sums;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q.corner_wt <= CORNER_RST;
      weights_q.edge_wt   <= EDGE_RST;
      weights_q.center_wt <= CENTER_RST;
      size_q              <= SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CORNER: weights_q.corner_wt <= cfg_data_i[WEIGHT_W-1:0];
        CFG_EDGE:   weights_q.edge_wt   <= cfg_data_i[WEIGHT_W-1:0];
        CFG_CENTER: weights_q.center_wt <= cfg_data_i[WEIGHT_W-1:0];
        CFG_SIZE:   size_q              <= cfg_data_i[SIZE_W-1:0];
      endcase
    end
  end

  sst_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .image_size_i (size_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .sums_valid_o (sums_valid),
    .sums_ready_i (sums_ready),
    .sums_o       (sums)
  );

  sst_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .weights_i    (weights_q),
    .sums_valid_i (sums_valid),
    .sums_ready_o (sums_ready),
    .sums_i       (sums),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_last_o   (out_last_o)
  );

endmodule

### design/sst_checker.sv
// port-level checks of the smoothing stencil core and their bind
`include "smoothing_3x3_stencil_core_defines.svh"

module sst_checker import sst_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [SAMPLE_W-1:0] out_value_o,
  input logic [IDX_W-1:0]           out_row_o,
  input logic [IDX_W-1:0]           out_col_o,
  input logic                       out_last_o
);

  // a stalled result keeps its value and position
  `SST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_value_o) && $stable(out_row_o) && $stable(out_col_o))

  // a result only disappears after it was taken
  `SST_ASSERT_NOW(a_out_taken, $fell(out_valid_o), $past(!out_stall_i))

  // only interior centers are reported
  `SST_ASSERT_NOW(a_interior, out_valid_o,
    out_row_o != '0 && out_col_o != '0 &&
    out_row_o != IDX_W'(MAX_SIZE - 1) && out_col_o != IDX_W'(MAX_SIZE - 1))

  // the frame ends on the bottom-right interior pixel of a square image
  `SST_ASSERT_NOW(a_last_diag, out_valid_o && out_last_o, out_row_o == out_col_o)

endmodule

bind smoothing_3x3_stencil_core sst_checker u_sst_checker (.*);

### verif/tb.sv
// testbench for the 3x3 smoothing stencil core
`timescale 1ns / 100ps

module tb import sst_pkg::*; ();

  localparam int LINE_DEPTH     = 4096;
  localparam int ROUND_SHIFT    = 14;
  localparam int CYCLE_LIMIT    = 2_500_000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_SAMPLES = 800;
  localparam int PRIME_SIDE     = 24;
  localparam int CLAMP_RUN      = 16;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic                       last;
  } smooth_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] out_value_o;
  logic [IDX_W-1:0]           out_row_o;
  logic [IDX_W-1:0]           out_col_o;
  logic                       out_last_o;

  // predictor state: weights, size code, line buffers, window, raster position
  bit signed [15:0] wt_corner = 16'sd819;
  bit signed [15:0] wt_edge   = 16'sd1638;
  bit signed [15:0] wt_center = 16'sd6554;
  bit [12:0]        size_reg  = 13'd4096;
  bit signed [15:0] row_above     [LINE_DEPTH];
  bit signed [15:0] row_two_above [LINE_DEPTH];
  bit signed [15:0] window        [6];
  int unsigned      col_pos;
  int unsigned      row_pos;

  smooth_result_t expected_pixels [$];

  int          mismatches;
  int          samples_sent;
  int unsigned cycle_count;
  bit          quiet;
  bit          long_hold_req;

  smoothing_3x3_stencil_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_last_o  (out_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned active_side();
    if (size_reg < 3) return 3;
    if (size_reg > LINE_DEPTH) return LINE_DEPTH;
    return size_reg;
  endfunction

  // advance the raster position by one sample and queue the smoothed pixel if any
  function automatic void smooth_predict(input logic signed [SAMPLE_W-1:0] px);
    int unsigned      side;
    bit signed [15:0] top;
    bit signed [15:0] mid;
    longint           corners;
    longint           sides;
    longint           acc;
    longint           q;
    smooth_result_t   res;
    side = active_side();
    if (col_pos >= side) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= side) row_pos = 0;
    top = row_two_above[col_pos];
    mid = row_above[col_pos];
    if (row_pos >= 2 && col_pos >= 2) begin
      corners = longint'(window[0]) + longint'(window[2]) + longint'(top) + longint'(px);
      sides   = longint'(window[3]) + longint'(window[5]) + longint'(window[1])
                + longint'(mid);
      acc = longint'(wt_corner) * corners + longint'(wt_edge) * sides
            + longint'(wt_center) * longint'(window[4]);
      // floor shift after adding half gives round half up
      q = (acc + 64'sd8192) >>> ROUND_SHIFT;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.value = SAMPLE_W'(q);
      res.row   = IDX_W'(row_pos - 1);
      res.col   = IDX_W'(col_pos - 1);
      res.last  = (row_pos == side - 1) && (col_pos == side - 1);
      expected_pixels.push_back(res);
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = top;
    window[4] = mid;
    window[5] = px;
    row_two_above[col_pos] = mid;
    row_above[col_pos]     = px;
    col_pos++;
    if (col_pos >= side) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= side) row_pos = 0;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return CFG_DATA_W'($urandom_range(0, 16384) - 8192);
    endcase
  endfunction

  task automatic program_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_CORNER: wt_corner = data;
      CFG_EDGE:   wt_edge   = data;
      CFG_CENTER: wt_center = data;
      CFG_SIZE:   size_reg  = data[12:0];
      default: ;
    endcase
  endtask

  task automatic program_weights(input logic [CFG_DATA_W-1:0] corner_wt,
                                 input logic [CFG_DATA_W-1:0] edge_wt,
                                 input logic [CFG_DATA_W-1:0] center_wt);
    program_reg(CFG_CORNER, corner_wt);
    program_reg(CFG_EDGE, edge_wt);
    program_reg(CFG_CENTER, center_wt);
  endtask

  // unused upper bits carry junk
  task automatic program_size(input int unsigned code);
    program_reg(CFG_SIZE, {3'($urandom), 13'(code)});
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] px);
    bit taken;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= px;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    smooth_predict(px);
    samples_sent++;
  endtask

  task automatic send_frame(input int unsigned count);
    repeat (count) send_sample(random_sample());
  endtask

  // sender stops until every queued pixel is out and the pipe has settled
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // reset weights, a short run at a size code past the maximum, then three rows
  // of the widest later frame so every column used afterwards holds written data
  task automatic test_reset_defaults();
    program_size(8191);
    send_frame(CLAMP_RUN);
    drain_results();
    program_size(PRIME_SIDE);
    send_frame(3 * PRIME_SIDE - CLAMP_RUN);
    drain_results();
  endtask

  // saturation both ways, size codes below the minimum, rounding of a negative half
  task automatic test_directed_extremes();
    int k;
    // position is at row 3 of the wide frame, so the row wraps here
    program_weights(16'h7fff, 16'h7fff, 16'h7fff);
    program_size(0);
    repeat (9) send_sample(16'sh7fff);
    drain_results();
    program_weights(16'h8000, 16'h8000, 16'h8000);
    program_size(1);
    repeat (9) send_sample(16'sh7fff);
    drain_results();
    program_weights(16'h0000, 16'h0000, 16'h2000);
    program_size(2);
    for (k = 0; k < 9; k++) send_sample((k == 4) ? -16'sd3 : 16'sh8000);
    drain_results();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    program_weights(random_weight(), random_weight(), random_weight());
    program_size(16);
    send_frame(32);
    long_hold_req = 1'b1;
    send_frame(16 * 16 - 32);
    drain_results();
  endtask

  // mostly whole frames with random weights and sizes, some cut short
  task automatic test_random_frames();
    int unsigned side;
    int unsigned code;
    int unsigned len;
    int          stop_at;
    bit          reprogram;
    stop_at   = samples_sent + RANDOM_SAMPLES;
    reprogram = 1'b1;
    while (samples_sent < stop_at) begin
      if (reprogram || $urandom_range(0, 9) < 6) begin
        drain_results();
        if ($urandom_range(0, 9) == 0) side = $urandom_range(13, PRIME_SIDE);
        else side = $urandom_range(3, 9);
        code = side;
        if (side == 3 && $urandom_range(0, 2) == 0) code = $urandom_range(0, 2);
        program_weights(random_weight(), random_weight(), random_weight());
        program_size(code);
      end
      side = active_side();
      len  = side * side;
      // a cut frame leaves the position mid-frame for the next size change
      reprogram = ($urandom_range(0, 6) == 0);
      if (reprogram) len = $urandom_range(1, len - 1);
      send_frame(len);
    end
    drain_results();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    program_weights(random_weight(), random_weight(), random_weight());
    program_size(8);
    send_frame(3 * 8 * 8);
    drain_results();
  endtask

  initial begin : receiver_stalls
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
    end
  end

  always @(negedge clk_i) begin : check_results
    smooth_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $error("unexpected result at row %0d col %0d", out_row_o, out_col_o);
      end else begin
        want = expected_pixels.pop_front();
        if (out_value_o !== want.value) begin
          mismatches++;
          $error("out_value: expected %0d, got %0d", want.value, out_value_o);
        end
        if (out_row_o !== want.row) begin
          mismatches++;
          $error("out_row: expected %0d, got %0d", want.row, out_row_o);
        end
        if (out_col_o !== want.col) begin
          mismatches++;
          $error("out_col: expected %0d, got %0d", want.col, out_col_o);
        end
        if (out_last_o !== want.last) begin
          mismatches++;
          $error("out_last: expected %0d, got %0d", want.last, out_last_o);
        end
      end
    end
  end

  initial begin
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_CORNER;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    sample_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_backpressure();
    test_random_frames();
    test_back_to_back();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/sst_pkg.sv
design/sst_line_ram.sv
design/sst_window.sv
design/sst_mac.sv
design/smoothing_3x3_stencil_core.sv
design/sst_checker.sv
verif/tb.sv
